@@ rtl/core/hbrc_pkg.sv @@
// Shared types, constants and codes for the H-bridge ramp motion controller.
package hbrc_pkg;

  // Field widths
  localparam int SPD_W      = 10;
  localparam int DUTY_W     = 10;
  localparam int GAIN_W     = 16;
  localparam int MOT_W      = 4;
  localparam int CODE_W     = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_FRAC  = 12;

  // Default duty resolution of the mapping curve
  localparam int DUTY_BITS_DEF = 10;

  // Register reset values
  localparam logic [DUTY_W-1:0] RST_MIN_DUTY  = 10'd50;
  localparam logic [DUTY_W-1:0] RST_MAX_DUTY  = 10'd1023;
  localparam logic [GAIN_W-1:0] RST_GAIN      = 16'd4096;
  localparam logic [SPD_W-1:0]  RST_TOP_SPEED = 10'd1000;
  localparam logic [SPD_W-1:0]  RST_RAMP_STEP = 10'd40;

  // Command bytes (ASCII)
  localparam logic [CODE_W-1:0] CMD_FWD   = 8'h46; // F
  localparam logic [CODE_W-1:0] CMD_BACK  = 8'h42; // B
  localparam logic [CODE_W-1:0] CMD_LEFT  = 8'h4C; // L
  localparam logic [CODE_W-1:0] CMD_RIGHT = 8'h52; // R
  localparam logic [CODE_W-1:0] CMD_FL    = 8'h47; // G
  localparam logic [CODE_W-1:0] CMD_FR    = 8'h49; // I
  localparam logic [CODE_W-1:0] CMD_BL    = 8'h48; // H
  localparam logic [CODE_W-1:0] CMD_BR    = 8'h4A; // J
  localparam logic [CODE_W-1:0] CMD_STOP  = 8'h53; // S
  localparam logic [CODE_W-1:0] CMD_CAL_A = 8'h61; // a
  localparam logic [CODE_W-1:0] CMD_CAL_B = 8'h62; // b
  localparam logic [CODE_W-1:0] CMD_CAL_C = 8'h63; // c
  localparam logic [CODE_W-1:0] CMD_CAL_D = 8'h64; // d

  typedef enum logic [MOT_W-1:0] {
    MOT_STOP  = 4'd0,
    MOT_FWD   = 4'd1,
    MOT_BACK  = 4'd2,
    MOT_LEFT  = 4'd3,
    MOT_RIGHT = 4'd4,
    MOT_FL    = 4'd5,
    MOT_FR    = 4'd6,
    MOT_BL    = 4'd7,
    MOT_BR    = 4'd8
  } hbrc_motion_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_MIN   = 4'd0,
    REG_LEFT_MAX   = 4'd1,
    REG_LEFT_GAIN  = 4'd2,
    REG_RIGHT_MIN  = 4'd3,
    REG_RIGHT_MAX  = 4'd4,
    REG_RIGHT_GAIN = 4'd5,
    REG_TOP_SPEED  = 4'd6,
    REG_RAMP_STEP  = 4'd7
  } hbrc_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_CORR,
    ST_GAIN,
    ST_OUT
  } hbrc_state_t;

  // Input word
  typedef struct packed {
    logic              cmd_valid;
    logic [CODE_W-1:0] cmd_code;
  } hbrc_in_t;

  // Result word
  typedef struct packed {
    logic              left_in1;
    logic              left_in2;
    logic [DUTY_W-1:0] left_duty;
    logic              right_in1;
    logic              right_in2;
    logic [DUTY_W-1:0] right_duty;
    logic [MOT_W-1:0]  active_motion;
    logic [SPD_W-1:0]  ramp_speed;
  } hbrc_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic mul_en;
    logic div_en;
    logic corr_en;
    logic gain_en;
    logic out_load;
  } hbrc_cmd_t;

endpackage

@@ rtl/core/hbrc_ctrl.sv @@
// Sequencing state machine for the motion controller.
module hbrc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  output hbrc_pkg::hbrc_cmd_t cmd
);
  import hbrc_pkg::*;

  hbrc_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MUL;
      end
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_CORR;
      ST_CORR: state_nxt = ST_GAIN;
      ST_GAIN: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_MUL:  cmd.mul_en  = 1'b1;
      ST_DIV:  cmd.div_en  = 1'b1;
      ST_CORR: cmd.corr_en = 1'b1;
      ST_GAIN: cmd.gain_en = 1'b1;
      ST_OUT:  cmd.out_load = !out_valid_r || out_ready;
      default: cmd = '0;
    endcase
  end

  // Output word valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == ST_MUL)
    else $error("accepted word did not start the sequence");

  a_gain_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_GAIN |=> state_r == ST_OUT)
    else $error("gain stage not followed by output stage");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("pending result dropped");

  a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result raised outside output stage");

endmodule

@@ rtl/core/hbrc_duty.sv @@
// One side's duty curve: range multiply, reciprocal divide, correction, gain.
module hbrc_duty #(
  parameter int DUTY_BITS = hbrc_pkg::DUTY_BITS_DEF
) (
  input  logic                          clk,
  input  hbrc_pkg::hbrc_cmd_t           cmd,
  input  logic [hbrc_pkg::SPD_W-1:0]    speed,
  input  logic [hbrc_pkg::DUTY_W-1:0]   min_duty,
  input  logic [hbrc_pkg::DUTY_W-1:0]   max_duty,
  input  logic [hbrc_pkg::GAIN_W-1:0]   gain,
  output logic [hbrc_pkg::DUTY_W-1:0]   duty
);
  import hbrc_pkg::*;

  localparam int CMP_W   = (DUTY_BITS > SPD_W) ? DUTY_BITS : SPD_W;
  localparam int PROD_W  = SPD_W + DUTY_W;
  localparam int SHIFT   = PROD_W + DUTY_BITS;
  localparam int RECIP_W = PROD_W + 1;
  localparam int EST_W   = PROD_W + RECIP_W;
  localparam int QE_W    = EST_W - SHIFT;
  localparam int BACK_W  = QE_W + DUTY_BITS;
  localparam int Q_W     = SPD_W + 1;
  localparam int M_W     = SPD_W + 2;
  localparam int GP_W    = DUTY_W + GAIN_W;
  localparam int P_W     = GP_W - GAIN_FRAC;
  localparam logic [DUTY_BITS-1:0] FULL = '1;
  localparam logic [63:0] RECIP_L = (64'd1 << SHIFT) / ((64'd1 << DUTY_BITS) - 64'd1);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_L[RECIP_W-1:0];

  logic [PROD_W-1:0] prod_r;
  logic              neg_r;
  logic [QE_W-1:0]   qe_r;
  logic [DUTY_W-1:0] m_r;
  logic              m_pos_r;
  logic [GP_W-1:0]   gp_r;

  logic [SPD_W-1:0]  s;
  logic [DUTY_W-1:0] dabs;
  logic              neg;
  logic [EST_W-1:0]  est;
  logic [BACK_W-1:0] back, rem;
  logic              inc;
  logic [Q_W-1:0]    q;
  logic [M_W-1:0]    m;
  logic [P_W-1:0]    p;

  // Stage 1: clamp speed, s * |max - min|
  always_comb begin
    s    = (CMP_W'(speed) > CMP_W'(FULL)) ? SPD_W'(FULL) : speed;
    neg  = max_duty < min_duty;
    dabs = neg ? (min_duty - max_duty) : (max_duty - min_duty);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= s * dabs;
      neg_r  <= neg;
    end
  end

  // Stage 2: quotient estimate by reciprocal, at most one low
  assign est = EST_W'(prod_r) * EST_W'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.div_en) qe_r <= est[EST_W-1 -: QE_W];
  end

  // Stage 3: remainder correction, then signed offset by min duty
  always_comb begin
    back = (BACK_W'(qe_r) << DUTY_BITS) - BACK_W'(qe_r);
    rem  = BACK_W'(prod_r) - back;
    inc  = rem >= BACK_W'(FULL);
    q    = Q_W'(qe_r) + Q_W'(inc);
    m    = neg_r ? (M_W'(min_duty) - M_W'(q)) : (M_W'(min_duty) + M_W'(q));
  end

  always_ff @(posedge clk) begin
    if (cmd.corr_en) begin
      m_r     <= m[DUTY_W-1:0];
      m_pos_r <= !m[M_W-1] && (m != '0);
    end
  end

  // Stage 4: Q4.12 gain
  always_ff @(posedge clk) begin
    if (cmd.gain_en) gp_r <= m_r * gain;
  end

  // Clamp to ceiling; zero when the offset duty is not positive
  always_comb begin
    p = gp_r[GP_W-1:GAIN_FRAC];
    if (!m_pos_r) duty = '0;
    else if (p > P_W'(max_duty)) duty = max_duty;
    else duty = p[DUTY_W-1:0];
  end

endmodule

@@ rtl/core/hbrc_datapath.sv @@
// Registers, motion state, speed ramp, duty lanes and result register.
module hbrc_datapath #(
  parameter int DUTY_BITS = hbrc_pkg::DUTY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hbrc_pkg::hbrc_cmd_t             cmd,
  input  hbrc_pkg::hbrc_in_t              in_data,
  output hbrc_pkg::hbrc_out_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hbrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hbrc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hbrc_pkg::*;

  logic [DUTY_W-1:0] lmin_r, lmax_r, rmin_r, rmax_r;
  logic [GAIN_W-1:0] lgain_r, rgain_r;
  logic [SPD_W-1:0]  top_r, step_r;

  hbrc_motion_t      cur_r, cur_nxt, want_r, want_nxt;
  logic [SPD_W-1:0]  speed_r, speed_nxt;
  hbrc_out_t         out_r;

  logic [SPD_W-1:0]  target;
  logic [SPD_W:0]    sum;
  logic [SPD_W-1:0]  gap;
  logic [DUTY_W-1:0] lduty, rduty;
  logic              drive;
  logic [1:0]        lbr, rbr;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lmin_r  <= RST_MIN_DUTY;
      lmax_r  <= RST_MAX_DUTY;
      lgain_r <= RST_GAIN;
      rmin_r  <= RST_MIN_DUTY;
      rmax_r  <= RST_MAX_DUTY;
      rgain_r <= RST_GAIN;
      top_r   <= RST_TOP_SPEED;
      step_r  <= RST_RAMP_STEP;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEFT_MIN:   lmin_r  <= cfg_data[DUTY_W-1:0];
        REG_LEFT_MAX:   lmax_r  <= cfg_data[DUTY_W-1:0];
        REG_LEFT_GAIN:  lgain_r <= cfg_data[GAIN_W-1:0];
        REG_RIGHT_MIN:  rmin_r  <= cfg_data[DUTY_W-1:0];
        REG_RIGHT_MAX:  rmax_r  <= cfg_data[DUTY_W-1:0];
        REG_RIGHT_GAIN: rgain_r <= cfg_data[GAIN_W-1:0];
        REG_TOP_SPEED:  top_r   <= cfg_data[SPD_W-1:0];
        REG_RAMP_STEP:  step_r  <= cfg_data[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // Command decode
  always_comb begin
    want_nxt = want_r;
    if (in_data.cmd_valid) begin
      case (in_data.cmd_code)
        CMD_FWD:   want_nxt = MOT_FWD;
        CMD_BACK:  want_nxt = MOT_BACK;
        CMD_LEFT:  want_nxt = MOT_LEFT;
        CMD_RIGHT: want_nxt = MOT_RIGHT;
        CMD_FL:    want_nxt = MOT_FL;
        CMD_FR:    want_nxt = MOT_FR;
        CMD_BL:    want_nxt = MOT_BL;
        CMD_BR:    want_nxt = MOT_BR;
        CMD_CAL_A, CMD_CAL_B, CMD_CAL_C, CMD_CAL_D: want_nxt = want_r;
        default:   want_nxt = MOT_STOP;
      endcase
    end
  end

  // Motion switch happens only at standstill; then slew toward target
  always_comb begin
    cur_nxt = cur_r;
    target  = '0;
    if (cur_r != want_nxt) begin
      if (speed_r == '0) begin
        cur_nxt = want_nxt;
        target  = (want_nxt == MOT_STOP) ? '0 : top_r;
      end
    end else begin
      target = (cur_r == MOT_STOP) ? '0 : top_r;
    end
    sum       = {1'b0, speed_r} + {1'b0, step_r};
    gap       = speed_r - target;
    speed_nxt = speed_r;
    if (speed_r < target) begin
      speed_nxt = (sum > {1'b0, target}) ? target : sum[SPD_W-1:0];
    end else if (speed_r > target) begin
      speed_nxt = (gap < step_r) ? target : (speed_r - step_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= MOT_STOP;
      want_r  <= MOT_STOP;
      speed_r <= '0;
    end else if (cmd.accept) begin
      cur_r   <= cur_nxt;
      want_r  <= want_nxt;
      speed_r <= speed_nxt;
    end
  end

  // Duty lanes
  hbrc_duty #(.DUTY_BITS(DUTY_BITS)) u_left (
    .clk      (clk),
    .cmd      (cmd),
    .speed    (speed_r),
    .min_duty (lmin_r),
    .max_duty (lmax_r),
    .gain     (lgain_r),
    .duty     (lduty)
  );

  hbrc_duty #(.DUTY_BITS(DUTY_BITS)) u_right (
    .clk      (clk),
    .cmd      (cmd),
    .speed    (speed_r),
    .min_duty (rmin_r),
    .max_duty (rmax_r),
    .gain     (rgain_r),
    .duty     (rduty)
  );

  // Bridge levels; stop and diagonals brake
  always_comb begin
    drive = 1'b1;
    lbr   = 2'b11;
    rbr   = 2'b11;
    case (cur_r)
      MOT_FWD:   begin lbr = 2'b10; rbr = 2'b10; end
      MOT_BACK:  begin lbr = 2'b01; rbr = 2'b01; end
      MOT_LEFT:  begin lbr = 2'b01; rbr = 2'b10; end
      MOT_RIGHT: begin lbr = 2'b10; rbr = 2'b01; end
      default:   drive = 1'b0;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.left_in1      <= lbr[1];
      out_r.left_in2      <= lbr[0];
      out_r.left_duty     <= (drive && speed_r != '0) ? lduty : '0;
      out_r.right_in1     <= rbr[1];
      out_r.right_in2     <= rbr[0];
      out_r.right_duty    <= (drive && speed_r != '0) ? rduty : '0;
      out_r.active_motion <= cur_r;
      out_r.ramp_speed    <= speed_r;
    end
  end

  assign out_data = out_r;

endmodule

@@ rtl/core/hbridge_ramp_motion_controller.sv @@
// Top level of the H-bridge soft-start ramp motion controller.
// One input word is one control period; it yields exactly one result word.
// A word is accepted only while the sequencer is idle. The accepting edge
// updates motion and ramped speed; the datapath stages then run in order (range
// multiply, reciprocal divide, remainder correction with min offset, Q4.12 gain
// multiply), and the output stage clamps and loads the result register, which
// makes the result word valid. The next word can be accepted on the edge after
// that load, so no new word is taken while one is still in work. Both bridge
// sides run in parallel lanes. A finished result waits in its own register, so
// the next word can be accepted before the previous result is taken, but a
// result load waits while that register is still full.
// Configuration writes are always ready and take effect at once; write only
// between words.
module hbridge_ramp_motion_controller #(
  parameter int DUTY_BITS = hbrc_pkg::DUTY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  hbrc_pkg::hbrc_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output hbrc_pkg::hbrc_out_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hbrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hbrc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hbrc_pkg::*;

  hbrc_cmd_t cmd;

  hbrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  hbrc_datapath #(.DUTY_BITS(DUTY_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

@@ sim/hbrc_motion_checker.sv @@
// Checker for the H-bridge ramp controller: predicts each result word and compares it.
module hbrc_motion_checker #(
  parameter int DUTY_BITS = hbrc_pkg::DUTY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  hbrc_pkg::hbrc_in_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  hbrc_pkg::hbrc_out_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [hbrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hbrc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              pending,
  output int                              fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import hbrc_pkg::*;

  // Shadow copy of the register file
  logic [DUTY_W-1:0] lmin_q, lmax_q, rmin_q, rmax_q;
  logic [GAIN_W-1:0] lgain_q, rgain_q;
  logic [SPD_W-1:0]  top_q, step_q;

  // Shadow copy of the motion state
  hbrc_motion_t      cur_motion, want_motion;
  logic [SPD_W-1:0]  speed_q;

  hbrc_out_t         expected_words[$];
  int                mismatches = 0;

  // Speed to duty: linear map into min..max, Q4.12 gain, clamp to 0..max
  function automatic logic [DUTY_W-1:0] map_duty(logic [SPD_W-1:0] spd,
                                                 logic [DUTY_W-1:0] mn,
                                                 logic [DUTY_W-1:0] mx,
                                                 logic [GAIN_W-1:0] gain);
    longint full, s, m, p;
    full = (longint'(1) << DUTY_BITS) - 1;
    if (spd == '0) return '0;
    s = longint'(spd);
    if (s > full) s = full;
    // signed division truncates toward zero, so min above max maps downward
    m = longint'(mn) + (s * (longint'(mx) - longint'(mn))) / full;
    if (m <= 0) return '0;
    p = (m * longint'(gain)) / (longint'(1) << GAIN_FRAC);
    if (p > longint'(mx)) p = longint'(mx);
    return DUTY_W'(p);
  endfunction

  // One control period: decode, ramp, bridge levels, duties
  function automatic hbrc_out_t advance_period(hbrc_in_t w);
    hbrc_out_t r;
    int        target, nxt, stp;
    logic      drive;
    if (w.cmd_valid) begin
      case (w.cmd_code)
        CMD_FWD:   want_motion = MOT_FWD;
        CMD_BACK:  want_motion = MOT_BACK;
        CMD_LEFT:  want_motion = MOT_LEFT;
        CMD_RIGHT: want_motion = MOT_RIGHT;
        CMD_FL:    want_motion = MOT_FL;
        CMD_FR:    want_motion = MOT_FR;
        CMD_BL:    want_motion = MOT_BL;
        CMD_BR:    want_motion = MOT_BR;
        CMD_STOP:  want_motion = MOT_STOP;
        CMD_CAL_A, CMD_CAL_B, CMD_CAL_C, CMD_CAL_D: ;
        default:   want_motion = MOT_STOP;
      endcase
    end

    // a motion change waits until the speed has come down to zero
    target = 0;
    if (cur_motion == want_motion || speed_q == '0) begin
      cur_motion = want_motion;
      target = (cur_motion == MOT_STOP) ? 0 : int'(top_q);
    end

    // slew toward target without overshoot
    nxt = int'(speed_q);
    stp = int'(step_q);
    if (nxt < target) begin
      nxt = nxt + stp;
      if (nxt > target) nxt = target;
    end else if (nxt > target) begin
      if (nxt - target < stp) nxt = target;
      else nxt = nxt - stp;
    end
    speed_q = SPD_W'(nxt);

    r = '0;
    drive = 1'b1;
    case (cur_motion)
      MOT_FWD:   {r.left_in1, r.left_in2, r.right_in1, r.right_in2} = 4'b1010;
      MOT_BACK:  {r.left_in1, r.left_in2, r.right_in1, r.right_in2} = 4'b0101;
      MOT_LEFT:  {r.left_in1, r.left_in2, r.right_in1, r.right_in2} = 4'b0110;
      MOT_RIGHT: {r.left_in1, r.left_in2, r.right_in1, r.right_in2} = 4'b1001;
      default: begin
        // stop and diagonals brake both sides
        {r.left_in1, r.left_in2, r.right_in1, r.right_in2} = 4'b1111;
        drive = 1'b0;
      end
    endcase
    if (drive) begin
      r.left_duty  = map_duty(speed_q, lmin_q, lmax_q, lgain_q);
      r.right_duty = map_duty(speed_q, rmin_q, rmax_q, rgain_q);
    end
    r.active_motion = cur_motion;
    r.ramp_speed    = speed_q;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    hbrc_out_t want;
    if (!rst_n) begin
      lmin_q      = RST_MIN_DUTY;
      lmax_q      = RST_MAX_DUTY;
      lgain_q     = RST_GAIN;
      rmin_q      = RST_MIN_DUTY;
      rmax_q      = RST_MAX_DUTY;
      rgain_q     = RST_GAIN;
      top_q       = RST_TOP_SPEED;
      step_q      = RST_RAMP_STEP;
      cur_motion  = MOT_STOP;
      want_motion = MOT_STOP;
      speed_q     = '0;
      expected_words.delete();
    end else begin
      // register writes; indexes past the last register are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LEFT_MIN:   lmin_q  = cfg_data[DUTY_W-1:0];
          REG_LEFT_MAX:   lmax_q  = cfg_data[DUTY_W-1:0];
          REG_LEFT_GAIN:  lgain_q = cfg_data[GAIN_W-1:0];
          REG_RIGHT_MIN:  rmin_q  = cfg_data[DUTY_W-1:0];
          REG_RIGHT_MAX:  rmax_q  = cfg_data[DUTY_W-1:0];
          REG_RIGHT_GAIN: rgain_q = cfg_data[GAIN_W-1:0];
          REG_TOP_SPEED:  top_q   = cfg_data[SPD_W-1:0];
          REG_RAMP_STEP:  step_q  = cfg_data[SPD_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready)
        expected_words.push_back(advance_period(in_data));

      // compare each accepted result word with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing pending: %h", out_data);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("left_in1",      want.left_in1,      out_data.left_in1);
          check_field("left_in2",      want.left_in2,      out_data.left_in2);
          check_field("left_duty",     want.left_duty,     out_data.left_duty);
          check_field("right_in1",     want.right_in1,     out_data.right_in1);
          check_field("right_in2",     want.right_in2,     out_data.right_in2);
          check_field("right_duty",    want.right_duty,    out_data.right_duty);
          check_field("active_motion", want.active_motion, out_data.active_motion);
          check_field("ramp_speed",    want.ramp_speed,    out_data.ramp_speed);
        end
      end
    end
    pending    <= expected_words.size();
    fail_count <= mismatches;
  end

endmodule

@@ sim/hbridge_ramp_motion_controller_tb.sv @@
// Testbench top for the H-bridge ramp controller: clock, reset, stimulus and verdict.
module hbridge_ramp_motion_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hbrc_pkg::*;

  localparam logic [CODE_W-1:0] MOVE_CODES [9] = '{
    CMD_FWD, CMD_BACK, CMD_LEFT, CMD_RIGHT, CMD_FL, CMD_FR, CMD_BL, CMD_BR, CMD_STOP
  };
  localparam logic [CODE_W-1:0] CAL_CODES [4] = '{CMD_CAL_A, CMD_CAL_B, CMD_CAL_C, CMD_CAL_D};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  hbrc_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  hbrc_out_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    pending;
  int                    fail_count;

  int unsigned           in_idle_pct = 0;
  int unsigned           out_stall_pct = 0;
  logic                  hold_go = 1'b0;
  int                    hold_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  hbridge_ramp_motion_controller DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hbrc_motion_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= 120;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Offer one command word; valid stays up after acceptance until the next call decides
  task automatic send_word(hbrc_in_t w);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every predicted word has come back
  task automatic drain(int tail);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Full register set; upper data bits of the 10-bit registers carry noise
  task automatic load_setting(logic [9:0] lmin, logic [9:0] lmax, logic [15:0] lgain,
                              logic [9:0] rmin, logic [9:0] rmax, logic [15:0] rgain,
                              logic [9:0] top, logic [9:0] step);
    cfg_write(REG_LEFT_MIN,   {6'($urandom), lmin});
    cfg_write(REG_LEFT_MAX,   {6'($urandom), lmax});
    cfg_write(REG_LEFT_GAIN,  lgain);
    cfg_write(REG_RIGHT_MIN,  {6'($urandom), rmin});
    cfg_write(REG_RIGHT_MAX,  {6'($urandom), rmax});
    cfg_write(REG_RIGHT_GAIN, rgain);
    cfg_write(REG_TOP_SPEED,  {6'($urandom), top});
    cfg_write(REG_RAMP_STEP,  {6'($urandom), step});
    // stray write past the register file must change nothing
    cfg_write(CFG_IDX_W'(int'(REG_RAMP_STEP) + 1 + $urandom_range(7)), 16'($urandom));
  endtask

  function automatic logic [9:0] pick10(int unsigned lo, int unsigned hi);
    case ($urandom_range(9))
      0:       return 10'(lo);
      1:       return 10'(hi);
      default: return 10'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic hbrc_in_t cmd_word(logic v, logic [CODE_W-1:0] code);
    hbrc_in_t w;
    w.cmd_valid = v;
    w.cmd_code  = code;
    return w;
  endfunction

  // Mostly motion commands and quiet periods so ramps develop; some noise
  function automatic hbrc_in_t random_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45)      return cmd_word(1'b0, 8'($urandom));
    else if (r < 82) return cmd_word(1'b1, MOVE_CODES[$urandom_range(8)]);
    else if (r < 90) return cmd_word(1'b1, CAL_CODES[$urandom_range(3)]);
    else             return cmd_word(1'b1, 8'($urandom));
  endfunction

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fast ramp so every motion shows up, then calibration and odd codes
    cfg_write(REG_RAMP_STEP, 16'd1023);
    foreach (MOVE_CODES[i]) begin
      send_word(cmd_word(1'b1, MOVE_CODES[i]));
      send_word(cmd_word(1'b0, 8'($urandom)));
    end
    foreach (CAL_CODES[i]) send_word(cmd_word(1'b1, CAL_CODES[i]));
    send_word(cmd_word(1'b1, 8'h00));
    send_word(cmd_word(1'b1, 8'hFF));
    send_word(cmd_word(1'b0, CMD_FWD));

    // Random phases, each with its own register setting and idling mode
    for (int ph = 0; ph < 8; ph++) begin
      drain(8);
      case (ph % 4)
        0: begin in_idle_pct = 0;  out_stall_pct <= 0;  end
        1: begin in_idle_pct = 74; out_stall_pct <= 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct <= 74; end
        default: begin in_idle_pct = 15; out_stall_pct <= 15; end
      endcase
      case (ph)
        0: load_setting(RST_MIN_DUTY, RST_MAX_DUTY, RST_GAIN, RST_MIN_DUTY, RST_MAX_DUTY,
                        RST_GAIN, RST_TOP_SPEED, RST_RAMP_STEP);
        // min above max on the left, zero gain on the right, fastest ramp
        1: load_setting(10'd1023, 10'd0, 16'hFFFF, 10'd0, 10'd1023, 16'h0000,
                        10'd1023, 10'd1023);
        // frozen speed
        2: load_setting(10'd600, 10'd300, 16'd8192, 10'd1023, 10'd1023, 16'd4095,
                        10'd1023, 10'd0);
        default: load_setting(pick10(0, 1023), pick10(0, 1023), 16'($urandom),
                              pick10(0, 1023), pick10(0, 1023), 16'($urandom),
                              pick10(0, 1023), pick10(1, 1023));
      endcase
      for (int k = 0; k < 90; k++) begin
        if (ph == 0 && k == 20) begin
          // long result hold-off while words keep coming
          hold_go  <= 1'b1;
          in_valid <= 1'b0;
          @(posedge clk);
          hold_go <= 1'b0;
        end
        if (k == 45) drain(0);
        send_word(random_word());
      end
    end

    drain(16);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
